@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/srnr_pkg.sv @@
package srnr_pkg;

  // Result slots per input item (a NAK/ACK frame plus the accept event)
  localparam int unsigned MAX_RESULTS = 7;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned SLOTS       = 1 << CNT_W;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned LEN_W       = 11;

  localparam logic [LEN_W-1:0] PAYLOAD_DEPTH = 11'd16;

  // Protocol bytes and header masks
  localparam logic [7:0] SYNC_BYTE  = 8'h54;
  localparam logic [7:0] HDB2_MASK  = 8'hFC;
  localparam logic [7:0] HDB2_MATCH = 8'h50;
  localparam logic [7:0] HDB1_MASK  = 8'hF0;
  localparam logic [7:0] HDB1_MATCH = 8'h30;
  localparam logic [7:0] LEN_MASK   = 8'h0F;
  localparam logic [1:0] ACK_REQ    = 2'b01;
  localparam logic [1:0] REPLY_NAK  = 2'b11;
  localparam logic [1:0] REPLY_ACK  = 2'b10;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ACCEPT  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_SYNC     = 4'd1,
    ST_HDB2     = 4'd2,
    ST_HDB1     = 4'd3,
    ST_DEST     = 4'd4,
    ST_DATA     = 4'd5,
    ST_CRC      = 4'd6,
    ST_HDB2_FWD = 4'd7,
    ST_HDB1_FWD = 4'd8,
    ST_DEST_FWD = 4'd9,
    ST_DATA_FWD = 4'd10
  } parse_state_e;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       value;
    logic [IDX_W-1:0] index;
  } result_t;

  // All results caused by one input item
  typedef struct packed {
    result_t [SLOTS-1:0] res;
    logic [CNT_W-1:0]    count;
  } bundle_t;

  // Low nibble n: n bytes below 8, else 8 << (n & 7)
  function automatic logic [LEN_W-1:0] decode_length(input logic [7:0] hdb1);
    logic [3:0] n;
    n = hdb1[3:0] & LEN_MASK[3:0];
    if (n[3]) begin
      decode_length = LEN_W'(11'd8 << n[2:0]);
    end else begin
      decode_length = LEN_W'(n);
    end
  endfunction

endpackage

@@ hdl/srnr_if.sv @@
// Input item channel
interface srnr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink (input valid, action, rx_byte, output ready);
endinterface

// Result item channel
interface srnr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [3:0] payload_index;
  logic       last;

  modport source (output valid, kind, value, payload_index, last, input ready);
  modport sink (input valid, kind, value, payload_index, last, output ready);
endinterface

@@ hdl/snap_ring_node_receiver_top.sv @@
// The first result of an item is presented in the cycle after the item is accepted.
// Results leave the result buffer one per cycle while the output is ready, and an
// item yields at most 7 results.
// The next item is taken in the cycle the previous item's last result is taken.
// Reset (async, active low) returns the parser to idle, clears the lock, header
// state and node address, and empties the result buffer.
module snap_ring_node_receiver_top import srnr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  srnr_in_if.sink    rx_i,
  srnr_out_if.source res_o
);

  bundle_t bundle;
  logic    empty_next;
  logic    accept;

  assign rx_i.ready = empty_next;
  assign accept     = rx_i.valid && empty_next;

  // Header parser and packet state
  srnr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .action_i   (rx_i.action),
    .rx_byte_i  (rx_i.rx_byte),
    .bundle_o   (bundle)
  );

  // Result register, drained one result per cycle while the output is ready
  srnr_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .bundle_i    (bundle),
    .empty_next_o(empty_next),
    .res_o       (res_o)
  );

endmodule

@@ hdl/srnr_parser.sv @@
module srnr_parser import srnr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       accept_i,
  input  logic       action_i,
  input  logic [7:0] rx_byte_i,
  output bundle_t    bundle_o
);

  parse_state_e     state_q, state_d;
  logic [7:0]       node_addr_q;
  logic [7:0]       hdb2_q, hdb2_d;
  logic [7:0]       hdb1_q, hdb1_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic [7:0]       src_q, src_d;
  logic             lock_q, lock_d;
  logic             ack_q, ack_d;

  logic [LEN_W-1:0] cnt_inc;
  logic [LEN_W-1:0] cnt_dec;
  logic [7:0]       frame [6];
  logic [CNT_W-1:0] base;

  assign cnt_inc = cnt_q + LEN_W'(1);
  assign cnt_dec = (cnt_q != '0) ? cnt_q - LEN_W'(1) : cnt_q;

  // ACK/NAK frame bytes
  always_comb begin
    frame[0] = SYNC_BYTE;
    frame[1] = {HDB2_MATCH[7:2], lock_q ? REPLY_NAK : REPLY_ACK};
    frame[2] = HDB1_MATCH;
    frame[3] = src_q;
    frame[4] = node_addr_q;
    frame[5] = 8'h00;
  end

  // Next-state logic
  always_comb begin
    state_d = state_q;
    hdb2_d  = hdb2_q;
    hdb1_d  = hdb1_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    src_d   = src_q;
    lock_d  = lock_q;
    ack_d   = ack_q;
    if (action_i) begin
      lock_d = 1'b0;
    end else begin
      case (state_q)
        ST_SYNC: begin
          hdb2_d = rx_byte_i;
          if ((rx_byte_i & HDB2_MASK) != HDB2_MATCH) begin
            state_d = ST_HDB2_FWD;
          end else begin
            ack_d   = (rx_byte_i[1:0] == ACK_REQ);
            state_d = ST_HDB2;
          end
        end
        ST_HDB2: begin
          hdb1_d  = rx_byte_i;
          len_d   = decode_length(rx_byte_i);
          state_d = ((rx_byte_i & HDB1_MASK) != HDB1_MATCH) ? ST_HDB1_FWD : ST_HDB1;
        end
        ST_HDB1: begin
          state_d = (rx_byte_i != node_addr_q) ? ST_DEST_FWD : ST_DEST;
        end
        ST_DEST: begin
          src_d   = rx_byte_i;
          cnt_d   = '0;
          state_d = (len_q == '0) ? ST_CRC : ST_DATA;
        end
        ST_DATA: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= len_q) begin
            state_d = ST_CRC;
          end
        end
        ST_CRC: begin
          lock_d  = 1'b1;
          state_d = ST_IDLE;
        end
        ST_HDB2_FWD: begin
          hdb1_d  = rx_byte_i;
          len_d   = decode_length(rx_byte_i);
          state_d = ST_HDB1_FWD;
        end
        ST_HDB1_FWD: begin
          state_d = ST_DEST_FWD;
        end
        ST_DEST_FWD: begin
          cnt_d   = len_q + LEN_W'(1);
          state_d = ST_DATA_FWD;
        end
        ST_DATA_FWD: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            state_d = ST_IDLE;
          end
        end
        default: begin
          state_d = (rx_byte_i == SYNC_BYTE) ? ST_SYNC : ST_IDLE;
        end
      endcase
    end
  end

  // Result list for the item at the input
  always_comb begin
    bundle_o = '0;
    base     = '0;
    if (!action_i) begin
      case (state_q)
        ST_SYNC: begin
          if ((rx_byte_i & HDB2_MASK) != HDB2_MATCH) begin
            bundle_o.res[0] = '{KIND_TX, SYNC_BYTE, '0};
            bundle_o.res[1] = '{KIND_TX, rx_byte_i, '0};
            bundle_o.count  = CNT_W'(2);
          end
        end
        ST_HDB2: begin
          if ((rx_byte_i & HDB1_MASK) != HDB1_MATCH) begin
            bundle_o.res[0] = '{KIND_TX, SYNC_BYTE, '0};
            bundle_o.res[1] = '{KIND_TX, hdb2_q, '0};
            bundle_o.res[2] = '{KIND_TX, rx_byte_i, '0};
            bundle_o.count  = CNT_W'(3);
          end
        end
        ST_HDB1: begin
          if (rx_byte_i != node_addr_q) begin
            bundle_o.res[0] = '{KIND_TX, SYNC_BYTE, '0};
            bundle_o.res[1] = '{KIND_TX, hdb2_q, '0};
            bundle_o.res[2] = '{KIND_TX, hdb1_q, '0};
            bundle_o.res[3] = '{KIND_TX, rx_byte_i, '0};
            bundle_o.count  = CNT_W'(4);
          end
        end
        ST_DATA: begin
          if (!lock_q && cnt_q < PAYLOAD_DEPTH) begin
            bundle_o.res[0] = '{KIND_PAYLOAD, rx_byte_i, cnt_q[IDX_W-1:0]};
            bundle_o.count  = CNT_W'(1);
          end
        end
        ST_CRC: begin
          // Accept event first when the lock is free, then the optional frame
          if (!lock_q) begin
            bundle_o.res[0] = '{KIND_ACCEPT, src_q, '0};
            base            = CNT_W'(1);
          end
          if (ack_q) begin
            for (int i = 0; i < 6; i++) begin
              bundle_o.res[base + CNT_W'(i)] = '{KIND_TX, frame[i], '0};
            end
            bundle_o.count = base + CNT_W'(6);
          end else begin
            bundle_o.count = base;
          end
        end
        ST_HDB2_FWD, ST_HDB1_FWD, ST_DEST_FWD, ST_DATA_FWD: begin
          bundle_o.res[0] = '{KIND_TX, rx_byte_i, '0};
          bundle_o.count  = CNT_W'(1);
        end
        default: begin
          bundle_o.count = '0;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      node_addr_q <= '0;
      hdb2_q      <= '0;
      hdb1_q      <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      src_q       <= '0;
      lock_q      <= 1'b0;
      ack_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_addr_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        state_q <= state_d;
        hdb2_q  <= hdb2_d;
        hdb1_q  <= hdb1_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
        src_q   <= src_d;
        lock_q  <= lock_d;
        ack_q   <= ack_d;
      end
    end
  end

endmodule

@@ hdl/srnr_result_buf.sv @@
module srnr_result_buf import srnr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  bundle_t bundle_i,
  output logic    empty_next_o,
  srnr_out_if.source res_o
);

  result_t [SLOTS-1:0] res_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    rd_q;
  logic                last;
  logic                take;

  assign res_o.valid         = (rd_q < cnt_q);
  assign last                = ({1'b0, rd_q} + (CNT_W+1)'(1)) == {1'b0, cnt_q};
  assign res_o.kind          = res_q[rd_q].kind;
  assign res_o.value         = res_q[rd_q].value;
  assign res_o.payload_index = res_q[rd_q].index;
  assign res_o.last          = last;
  assign take                = res_o.valid && res_o.ready;

  // Free for a new item once the final result leaves
  assign empty_next_o = !res_o.valid || (take && last);

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= bundle_i.res;
    end
  end

  // Drain pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      cnt_q <= bundle_i.count;
      rd_q  <= '0;
    end else if (take) begin
      rd_q <= rd_q + CNT_W'(1);
    end
  end

endmodule

@@ hdl/srnr_checker.sv @@
`include "assert_macros.svh"

module srnr_checker import srnr_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_action_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_kind_i,
  input logic [7:0] out_value_i,
  input logic [3:0] out_index_i,
  input logic       out_last_i
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // A stalled result keeps its value and kind
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_value_i) && $stable(out_kind_i), "stalled result changed")

  // A new item only enters once the previous item's results are gone
  `ASSERT_IMPLY(a_in_after_drain, clk_i, rst_ni, in_acc, !out_valid_i || (out_ready_i && out_last_i), "item accepted over pending results")

  // Only delivered payload carries a position
  `ASSERT_IMPLY(a_index_zero, clk_i, rst_ni, out_valid_i && (out_kind_i != KIND_PAYLOAD), out_index_i == '0, "position on non-payload result")

  // A lock release produces no result
  `ASSERT_NEXT(a_release_quiet, clk_i, rst_ni, in_acc && in_action_i, !out_valid_i, "lock release produced a result")

endmodule

bind snap_ring_node_receiver_top srnr_checker u_srnr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (rx_i.valid),
  .in_ready_i (rx_i.ready),
  .in_action_i(rx_i.action),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .out_kind_i (res_o.kind),
  .out_value_i(res_o.value),
  .out_index_i(res_o.payload_index),
  .out_last_i (res_o.last)
);
